/* hw/rtl/netstring_deframer_top_assert.svh */
// Assertion macros shared by the deframer checker.
`ifndef NETSTRING_DEFRAMER_TOP_ASSERT_SVH
`define NETSTRING_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define NSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Deframer assertion failed");

`endif

/* hw/rtl/nsd_pkg.sv */
// Shared types and constants of the netstring deframer.
`timescale 1ns / 1ps
package nsd_pkg;

  localparam int unsigned LenW = 24;
  localparam int unsigned TokenDepthDef = 4;
  localparam int unsigned ResultDepthDef = 4;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChZero = 8'h30;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindDone  = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] raw;
    logic       is_digit;
    logic       is_colon;
    logic       is_comma;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       payload;
    logic [LenW-1:0]  length;
  } result_t;

endpackage

/* hw/rtl/nsd_fifo.sv */
// Small first-in first-out queue with a register-array store.
`timescale 1ns / 1ps
module nsd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AddrW + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AddrW + 1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (AddrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/nsd_front.sv */
// Front end: accepts raw bytes and classifies them into tokens.
`timescale 1ns / 1ps
module nsd_front (
  input  logic           push_i,
  input  logic [7:0]     in_byte_i,
  output logic           full_o,
  output logic           tok_push_o,
  output nsd_pkg::token_t tok_o,
  input  logic           tok_full_i
);

  logic [7:0] offset;

  assign offset     = in_byte_i - nsd_pkg::ChZero;
  assign full_o     = tok_full_i;
  assign tok_push_o = push_i & ~tok_full_i;

  always_comb begin
    tok_o          = '0;
    tok_o.raw      = in_byte_i;
    tok_o.is_digit = (in_byte_i >= nsd_pkg::ChZero) && (offset <= 8'd9);
    tok_o.is_colon = (in_byte_i == nsd_pkg::ChColon);
    tok_o.is_comma = (in_byte_i == nsd_pkg::ChComma);
    tok_o.digit    = offset[3:0];
  end

endmodule

/* hw/rtl/nsd_back.sv */
// Back end: frame state machine that turns tokens into result records.
`timescale 1ns / 1ps
module nsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  nsd_pkg::token_t  tok_i,
  output logic             tok_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output nsd_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhPayload,
    PhTerm
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [2:0]                  hdr_cnt_q, hdr_cnt_d;
  logic [nsd_pkg::LenW-1:0]    len_q, len_d;
  logic [nsd_pkg::LenW-1:0]    rem_q, rem_d;
  logic [nsd_pkg::LenW-1:0]    rem_dec;
  logic [nsd_pkg::LenW-1:0]    len_next;
  logic                        fire;

  assign fire      = tok_valid_i & ~res_full_i;
  assign tok_pop_o = fire;
  assign rem_dec   = rem_q - nsd_pkg::LenW'(1);
  assign len_next  = (len_q << 3) + (len_q << 1) + nsd_pkg::LenW'(tok_i.digit);

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    len_d      = len_q;
    rem_d      = rem_q;
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.kind = nsd_pkg::KindData;
    if (fire) begin
      unique case (phase_q)
        PhPayload: begin
          rem_d         = rem_dec;
          res_push_o    = 1'b1;
          res_o.payload = tok_i.raw;
          if (rem_dec == '0) begin
            phase_d = PhTerm;
          end
        end
        PhTerm: begin
          phase_d    = PhHeader;
          hdr_cnt_d  = '0;
          len_d      = '0;
          rem_d      = '0;
          res_push_o = 1'b1;
          if (tok_i.is_comma) begin
            res_o.kind   = nsd_pkg::KindDone;
            res_o.length = len_q;
          end else begin
            res_o.kind = nsd_pkg::KindError;
          end
        end
        default: begin
          phase_d = PhHeader;
          priority if ((hdr_cnt_q == 3'd3 || hdr_cnt_q == 3'd7) && tok_i.is_colon) begin
            rem_d     = len_q;
            hdr_cnt_d = '0;
            phase_d   = (len_q == '0) ? PhTerm : PhPayload;
          end else if (hdr_cnt_q != 3'd7 && tok_i.is_digit) begin
            len_d     = len_next;
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end else begin
            hdr_cnt_d  = '0;
            len_d      = '0;
            rem_d      = '0;
            res_push_o = 1'b1;
            res_o.kind = nsd_pkg::KindError;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= '0;
      len_q     <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

endmodule

/* hw/rtl/netstring_deframer_top.sv */
// Netstring deframer top level: byte queue in, result queue out.
// Path: bytes are queued as tokens, and the frame state machine queues its results.
// Throughput: one byte per cycle while the result queue is not full.
// Reset: asynchronous, active low; clears both queues and returns to header collection.
`timescale 1ns / 1ps
module netstring_deframer_top #(
  parameter int unsigned TokenDepth  = nsd_pkg::TokenDepthDef,
  parameter int unsigned ResultDepth = nsd_pkg::ResultDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               in_byte_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               kind_o,
  output logic [7:0]               payload_byte_o,
  output logic [nsd_pkg::LenW-1:0] frame_length_o
);

  localparam int unsigned TokW = $bits(nsd_pkg::token_t);
  localparam int unsigned ResW = $bits(nsd_pkg::result_t);

  nsd_pkg::token_t  tok_in, tok_out;
  nsd_pkg::result_t res_in, res_out;
  logic [TokW-1:0]  tok_rdata;
  logic [ResW-1:0]  res_rdata;
  logic             tok_push, tok_full, tok_pop, tok_empty;
  logic             res_push, res_full;

  nsd_front u_front (
    .push_i     (push),
    .in_byte_i  (in_byte_i),
    .full_o     (full),
    .tok_push_o (tok_push),
    .tok_o      (tok_in),
    .tok_full_i (tok_full)
  );

  nsd_fifo #(
    .Width (TokW),
    .Depth (TokenDepth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .wdata_i (tok_in),
    .full_o  (tok_full),
    .pop_i   (tok_pop),
    .rdata_o (tok_rdata),
    .empty_o (tok_empty)
  );

  assign tok_out = nsd_pkg::token_t'(tok_rdata);

  nsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (~tok_empty),
    .tok_i       (tok_out),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  nsd_fifo #(
    .Width (ResW),
    .Depth (ResultDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_out        = nsd_pkg::result_t'(res_rdata);
  assign kind_o         = res_out.kind;
  assign payload_byte_o = res_out.payload;
  assign frame_length_o = res_out.length;

endmodule

/* hw/rtl/nsd_checker.sv */
// Port-level checker for the netstring deframer, with its bind statement.
`timescale 1ns / 1ps
`include "netstring_deframer_top_assert.svh"
module nsd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic [1:0]               kind_o,
  input logic [7:0]               payload_byte_o,
  input logic [nsd_pkg::LenW-1:0] frame_length_o
);

  logic out_valid;

  assign out_valid = ~empty;

  `NSD_ASSERT_IMPLY(a_kind_legal, clk_i, rst_ni, out_valid, kind_o == nsd_pkg::KindData || kind_o == nsd_pkg::KindDone || kind_o == nsd_pkg::KindError)
  `NSD_ASSERT_IMPLY(a_payload_zero, clk_i, rst_ni, out_valid && kind_o != nsd_pkg::KindData, payload_byte_o == 8'd0)
  `NSD_ASSERT_IMPLY(a_length_zero, clk_i, rst_ni, out_valid && kind_o != nsd_pkg::KindDone, frame_length_o == '0)
  `NSD_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !pop, !empty && $stable(kind_o) && $stable(payload_byte_o) && $stable(frame_length_o))

endmodule

bind netstring_deframer_top nsd_checker u_nsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .kind_o         (kind_o),
  .payload_byte_o (payload_byte_o),
  .frame_length_o (frame_length_o)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the netstring deframer top level.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 8;

  typedef enum bit [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTerm    = 2'd2
  } deframe_phase_e;

  class deframe_scoreboard;
    deframe_phase_e phase;
    bit [2:0] hdr_count;
    bit [nsd_pkg::LenW-1:0] len_acc;
    bit [nsd_pkg::LenW-1:0] remaining;
    nsd_pkg::result_t awaited[$];
    int unsigned failures;

    function new();
      restart();
      failures = 0;
    endfunction

    function void restart();
      phase = PhHeader;
      hdr_count = '0;
      len_acc = '0;
      remaining = '0;
    endfunction

    function void add(nsd_pkg::kind_e kind, bit [7:0] payload,
                      bit [nsd_pkg::LenW-1:0] length);
      nsd_pkg::result_t r;
      r.kind = kind;
      r.payload = payload;
      r.length = length;
      awaited.push_back(r);
    endfunction

    // Advances the frame state by one accepted byte and records what it yields.
    function void absorb_byte(bit [7:0] b);
      bit is_digit;
      bit [nsd_pkg::LenW-1:0] done_len;
      is_digit = (b >= nsd_pkg::ChZero) && (b <= nsd_pkg::ChZero + 8'd9);
      case (phase)
        PhPayload: begin
          remaining = remaining - 1'b1;
          if (remaining == '0) begin
            phase = PhTerm;
          end
          add(nsd_pkg::KindData, b, '0);
        end
        PhTerm: begin
          done_len = len_acc;
          restart();
          if (b == nsd_pkg::ChComma) begin
            add(nsd_pkg::KindDone, 8'h00, done_len);
          end else begin
            add(nsd_pkg::KindError, 8'h00, '0);
          end
        end
        default: begin
          phase = PhHeader;
          if ((hdr_count == 3'd3 || hdr_count == 3'd7) && b == nsd_pkg::ChColon) begin
            remaining = len_acc;
            hdr_count = '0;
            if (len_acc == '0) begin
              phase = PhTerm;
            end else begin
              phase = PhPayload;
            end
          end else if (hdr_count < 3'd7 && is_digit) begin
            len_acc = len_acc * 10 + (b - nsd_pkg::ChZero);
            hdr_count = hdr_count + 3'd1;
          end else begin
            restart();
            add(nsd_pkg::KindError, 8'h00, '0);
          end
        end
      endcase
    endfunction

    function void match_result(logic [1:0] kind, logic [7:0] payload,
                               logic [nsd_pkg::LenW-1:0] length);
      nsd_pkg::result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with none awaited: kind %0d payload %02h length %0d",
                 $time, kind, payload, length);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        failures++;
      end
      if (payload !== want.payload) begin
        $display("%0t: payload_byte expected %02h actual %02h", $time, want.payload, payload);
        failures++;
      end
      if (length !== want.length) begin
        $display("%0t: frame_length expected %0d actual %0d", $time, want.length, length);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [1:0] kind_o;
  logic [7:0] payload_byte_o;
  logic [nsd_pkg::LenW-1:0] frame_length_o;

  deframe_scoreboard sb = new();
  bit [7:0] stream_q[$];
  bit calm = 1'b0;
  int unsigned sent = 0;
  int unsigned cycle_count = 0;

  netstring_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_length_o(frame_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.match_result(kind_o, payload_byte_o, frame_length_o);
    end
    pop <= calm || ($urandom_range(99) >= 33);
  end

  function automatic bit [7:0] pick_junk(bit allow_colon, bit allow_digit);
    bit [7:0] b;
    b = 8'($urandom_range(255));
    while ((!allow_colon && b == nsd_pkg::ChColon) ||
           (!allow_digit && b >= nsd_pkg::ChZero && b <= nsd_pkg::ChZero + 8'd9)) begin
      b = 8'($urandom_range(255));
    end
    return b;
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      stream_q.push_back(s[i]);
    end
  endtask

  task automatic queue_header(int unsigned value, int unsigned width);
    bit [7:0] digits[7];
    for (int i = int'(width) - 1; i >= 0; i--) begin
      digits[i] = nsd_pkg::ChZero + 8'(value % 10);
      value = value / 10;
    end
    for (int i = 0; i < int'(width); i++) begin
      stream_q.push_back(digits[i]);
    end
    stream_q.push_back(nsd_pkg::ChColon);
  endtask

  // Builds one frame, mostly well formed, sometimes broken or replaced by noise.
  task automatic queue_frame(int unsigned forced_len);
    int unsigned width;
    int unsigned len;
    int unsigned pick;
    int unsigned start;
    int unsigned pos;
    int unsigned k;
    width = ($urandom_range(1) == 1) ? 7 : 3;
    pick = $urandom_range(99);
    if (forced_len != 0) begin
      width = 3;
      len = forced_len;
    end else if (pick < 8) begin
      len = 0;
    end else if (pick < 85) begin
      len = $urandom_range(12, 1);
    end else if (pick < 97) begin
      len = $urandom_range(120, 13);
    end else begin
      len = $urandom_range(300, 121);
    end
    pick = $urandom_range(99);
    if (forced_len == 0 && pick >= 90) begin
      if ($urandom_range(1) == 1) begin
        k = $urandom_range(7);
        for (int i = 0; i < int'(k); i++) begin
          stream_q.push_back(nsd_pkg::ChZero + 8'($urandom_range(9)));
        end
        stream_q.push_back(pick_junk(k != 3 && k != 7, k == 7));
      end else begin
        k = $urandom_range(4, 1);
        for (int i = 0; i < int'(k); i++) begin
          stream_q.push_back(pick_junk(0, 0));
        end
      end
      return;
    end
    start = stream_q.size();
    queue_header(len, width);
    for (int i = 0; i < int'(len); i++) begin
      stream_q.push_back(8'($urandom_range(255)));
    end
    stream_q.push_back(nsd_pkg::ChComma);
    if (forced_len == 0 && pick >= 82) begin
      pos = $urandom_range(width);
      stream_q[start + pos] = pick_junk(pos != width, 0);
    end else if (forced_len == 0 && pick >= 75) begin
      stream_q[stream_q.size() - 1] = pick_junk(1, 1);
    end
  endtask

  task automatic send_byte(bit [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 33) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    sb.absorb_byte(b);
    sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() != 0) begin
      send_byte(stream_q.pop_front());
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    bit paused;
    bit big_sent;
    paused = 1'b0;
    big_sent = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero length, colon too early, wide header with missing terminator,
    // and a non-digit in the upper half of a wide header.
    queue_text("000:,");
    queue_text("01:");
    queue_text("0000001:");
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    queue_text("0000x");
    send_stream();
    drain();

    while (sent < ItemTarget) begin
      if (!paused && sent > ItemTarget / 2) begin
        drain();
        paused = 1'b1;
      end
      calm = (sent >= 1150 && sent < 1450);
      if (!big_sent && sent > 100) begin
        queue_frame(999);
        big_sent = 1'b1;
      end else begin
        queue_frame(0);
      end
      send_stream();
    end
    calm = 1'b0;
    drain();
    repeat (TailCycles) @(posedge clk_i);

    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
